/* rtl/core/mcur_pkg.sv */
`default_nettype none

package mcur_pkg;

   // Default number of echo channels, and the fixed widths of the interface fields.
   localparam int NUM_CHANNELS_DEFAULT = 8;
   localparam int LEVELS_W             = 8;
   localparam int CHANNEL_W            = 3;
   localparam int STATUS_W             = 2;
   localparam int DIST_W               = 21;
   localparam int PERIOD_W             = 20;
   localparam int TRIGGER_W            = 10;
   localparam int WIDTH_W              = 20;
   localparam int CSR_INDEX_W          = 2;
   localparam int CSR_DATA_W           = 20;

   // Echo width times 17 fits in 25 bits.
   localparam int W17_W  = WIDTH_W + 5;
   localparam int PROD_W = W17_W + 32;

   // Divide by ten: multiply by ceil(2^35 / 10) and keep the bits from 35 up.
   localparam logic [31:0] RECIP_TEN       = 32'hCCCC_CCCD;
   localparam int          RECIP_TEN_SHIFT = 35;

   localparam logic [PERIOD_W-1:0]  PERIOD_RESET  = 20'd50000;
   localparam logic [TRIGGER_W-1:0] TRIGGER_RESET = 10'd100;
   localparam logic [WIDTH_W-1:0]   WIDTH_MAX     = 20'hF_FFFF;

   // Configuration register indexes.
   localparam logic [CSR_INDEX_W-1:0] CSR_PERIOD_TICKS  = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_TRIGGER_TICKS = 2'd1;

   // Reported echo status codes.
   localparam logic [STATUS_W-1:0] STATUS_NO_ECHO    = 2'd0;
   localparam logic [STATUS_W-1:0] STATUS_UNFINISHED = 2'd1;
   localparam logic [STATUS_W-1:0] STATUS_MEASURED   = 2'd2;

   typedef enum logic [1:0] {
      PHASE_IDLE   = 2'd0,
      PHASE_ARMED  = 2'd1,
      PHASE_TIMING = 2'd2,
      PHASE_DONE   = 2'd3
   } phase_type;

   // Per-tick control shared by every lane.
   typedef struct packed {
      logic accept;
      logic arm;
      logic sample;
   } lane_ctl_type;

   // What the time base tells the merging stage about an accepted tick.
   typedef struct packed {
      logic accept;
      logic is_last;
      logic trig;
   } tick_type;

endpackage

`default_nettype wire

/* rtl/core/multi_channel_ultrasonic_ranger.sv */
// Multi-channel ultrasonic echo ranger.
// Each request is one microsecond tick carrying the sampled echo level of every
// channel in req_echo_levels. A measurement period is period_ticks ticks long.
// At its start all channels are armed and the shared trigger output is high for
// trigger_ticks ticks. After that, each channel times its echo pulse in ticks.
// An ordinary tick gives one response with rsp_report_valid low. The last tick
// of a period gives NUM_CHANNELS responses, channels ascending, with status and
// distance in tenths of a millimetre; rsp_last marks the final one.
// The response to an ordinary tick is registered in stage one and then in the
// output register; a report tick first sets the busy state, then issues its responses.
// Ordinary ticks flow back to back unless the output stalls. A report tick holds
// off requests while the merging stage walks the lanes, one channel per cycle when
// not stalled. When the receiver stalls, the output register and the stage behind
// it hold, and req_stall rises. Reset clears the tick counter and all channel phases
// and loads period 50000 and trigger 100. Configuration writes through the csr_
// port are meant for when no requests are in flight.
`default_nettype none

module multi_channel_ultrasonic_ranger #(
   parameter int NUM_CHANNELS = mcur_pkg::NUM_CHANNELS_DEFAULT
) (
   input  wire logic                                clock,
   input  wire logic                                reset,
   input  wire logic                                csr_write_enable,
   input  wire logic [mcur_pkg::CSR_INDEX_W-1:0]    csr_index,
   input  wire logic [mcur_pkg::CSR_DATA_W-1:0]     csr_write_data,
   input  wire logic                                req_valid,
   output logic                                     req_stall,
   input  wire logic [mcur_pkg::LEVELS_W-1:0]       req_echo_levels,
   output logic                                     rsp_valid,
   input  wire logic                                rsp_stall,
   output logic                                     rsp_trigger_level,
   output logic                                     rsp_report_valid,
   output logic [mcur_pkg::CHANNEL_W-1:0]           rsp_channel,
   output logic [mcur_pkg::STATUS_W-1:0]            rsp_echo_status,
   output logic [mcur_pkg::DIST_W-1:0]              rsp_distance_tenth_mm,
   output logic                                     rsp_last
);

   logic [mcur_pkg::PERIOD_W-1:0]   period_ticks_ff, period_ticks_in;
   logic [mcur_pkg::TRIGGER_W-1:0]  trigger_ticks_ff, trigger_ticks_in;
   logic [mcur_pkg::PERIOD_W-1:0]   period_counter_ff, period_counter_in;
   logic [mcur_pkg::PERIOD_W:0]     counter_next;
   logic                            req_accept;
   logic                            trig;
   logic                            is_last;

   mcur_pkg::lane_ctl_type          lane_ctl;
   mcur_pkg::tick_type              tick;
   mcur_pkg::phase_type             lane_phase [NUM_CHANNELS];
   logic [mcur_pkg::WIDTH_W-1:0]    lane_width [NUM_CHANNELS];

   assign req_accept = req_valid && !req_stall;

   // Configuration registers.
   always_comb begin
      period_ticks_in  = period_ticks_ff;
      trigger_ticks_in = trigger_ticks_ff;
      if (csr_write_enable) begin
         case (csr_index)
            mcur_pkg::CSR_PERIOD_TICKS:  period_ticks_in = csr_write_data;
            mcur_pkg::CSR_TRIGGER_TICKS:
               trigger_ticks_in = csr_write_data[mcur_pkg::TRIGGER_W-1:0];
            default: begin
            end
         endcase
      end
   end

   // Time base: the trigger is high while the counter is below trigger_ticks, and
   // the tick whose successor reaches the period length closes the period. A
   // period shortened below the running count therefore closes at once.
   assign counter_next = {1'b0, period_counter_ff} + (mcur_pkg::PERIOD_W + 1)'(1);
   assign trig         = period_counter_ff < mcur_pkg::PERIOD_W'(trigger_ticks_ff);
   assign is_last      = counter_next >= {1'b0, period_ticks_ff};

   always_comb begin
      period_counter_in = period_counter_ff;
      if (req_accept) begin
         period_counter_in = is_last ? '0 : counter_next[mcur_pkg::PERIOD_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         period_ticks_ff   <= mcur_pkg::PERIOD_RESET;
         trigger_ticks_ff  <= mcur_pkg::TRIGGER_RESET;
         period_counter_ff <= '0;
      end else begin
         period_ticks_ff   <= period_ticks_in;
         trigger_ticks_ff  <= trigger_ticks_in;
         period_counter_ff <= period_counter_in;
      end
   end

   // Every lane arms on the first tick of a period and samples its echo once the
   // trigger phase is over.
   assign lane_ctl.accept = req_accept;
   assign lane_ctl.arm    = (period_counter_ff == '0);
   assign lane_ctl.sample = !trig;

   genvar c;
   generate
      for (c = 0; c < NUM_CHANNELS; c++) begin : g_lane
         mcur_lane u_lane (
            .clock (clock),
            .reset (reset),
            .ctl   (lane_ctl),
            .level (req_echo_levels[c]),
            .phase (lane_phase[c]),
            .width (lane_width[c])
         );
      end
   endgenerate

   assign tick.accept  = req_accept;
   assign tick.is_last = is_last;
   assign tick.trig    = trig;

   // The merging stage turns ticks and lane results into the response stream.
   mcur_merge #(
      .NUM_CHANNELS (NUM_CHANNELS)
   ) u_merge (
      .clock                 (clock),
      .reset                 (reset),
      .tick                  (tick),
      .lane_phase            (lane_phase),
      .lane_width            (lane_width),
      .req_stall             (req_stall),
      .rsp_valid             (rsp_valid),
      .rsp_stall             (rsp_stall),
      .rsp_trigger_level     (rsp_trigger_level),
      .rsp_report_valid      (rsp_report_valid),
      .rsp_channel           (rsp_channel),
      .rsp_echo_status       (rsp_echo_status),
      .rsp_distance_tenth_mm (rsp_distance_tenth_mm),
      .rsp_last              (rsp_last)
   );

endmodule

`default_nettype wire

/* rtl/core/mcur_lane.sv */
`default_nettype none

module mcur_lane (
   input  wire logic                                clock,
   input  wire logic                                reset,
   input  wire mcur_pkg::lane_ctl_type              ctl,
   input  wire logic                                level,
   output mcur_pkg::phase_type                      phase,
   output logic [mcur_pkg::WIDTH_W-1:0]             width
);

   mcur_pkg::phase_type                 phase_ff, phase_in, phase_cur;
   logic [mcur_pkg::WIDTH_W-1:0]        width_ff, width_in;

   always_comb begin
      phase_cur = ctl.arm ? mcur_pkg::PHASE_ARMED : phase_ff;
      phase_in  = phase_ff;
      width_in  = width_ff;
      if (ctl.accept) begin
         phase_in = phase_cur;
         if (ctl.sample) begin
            case (phase_cur)
               mcur_pkg::PHASE_ARMED: begin
                  if (level) begin
                     phase_in = mcur_pkg::PHASE_TIMING;
                     width_in = mcur_pkg::WIDTH_W'(1);
                  end
               end
               mcur_pkg::PHASE_TIMING: begin
                  if (level) begin
                     if (width_ff != mcur_pkg::WIDTH_MAX) begin
                        width_in = width_ff + mcur_pkg::WIDTH_W'(1);
                     end
                  end else begin
                     phase_in = mcur_pkg::PHASE_DONE;
                  end
               end
               default: begin
               end
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= mcur_pkg::PHASE_IDLE;
         width_ff <= '0;
      end else begin
         phase_ff <= phase_in;
         width_ff <= width_in;
      end
   end

   assign phase = phase_ff;
   assign width = width_ff;

endmodule

`default_nettype wire

/* rtl/core/mcur_merge.sv */
`default_nettype none

module mcur_merge #(
   parameter int NUM_CHANNELS = mcur_pkg::NUM_CHANNELS_DEFAULT
) (
   input  wire logic                                clock,
   input  wire logic                                reset,
   input  wire mcur_pkg::tick_type                  tick,
   input  wire mcur_pkg::phase_type                 lane_phase [NUM_CHANNELS],
   input  wire logic [mcur_pkg::WIDTH_W-1:0]        lane_width [NUM_CHANNELS],
   output logic                                     req_stall,
   output logic                                     rsp_valid,
   input  wire logic                                rsp_stall,
   output logic                                     rsp_trigger_level,
   output logic                                     rsp_report_valid,
   output logic [mcur_pkg::CHANNEL_W-1:0]           rsp_channel,
   output logic [mcur_pkg::STATUS_W-1:0]            rsp_echo_status,
   output logic [mcur_pkg::DIST_W-1:0]              rsp_distance_tenth_mm,
   output logic                                     rsp_last
);

   localparam int SEL_W = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;
   localparam logic [SEL_W-1:0] SEL_LAST = SEL_W'(NUM_CHANNELS - 1);

   logic                                advance;
   logic                                busy_ff, busy_in;
   logic [SEL_W-1:0]                    sel_ff, sel_in;
   logic                                rep_trig_ff, rep_trig_in;

   // Issue slot, then stage one, then the output register.
   logic                                iss_valid, iss_trig, iss_report, iss_last;
   logic [mcur_pkg::CHANNEL_W-1:0]      iss_channel;
   logic [mcur_pkg::STATUS_W-1:0]       iss_status;
   logic [mcur_pkg::W17_W-1:0]          iss_w17;
   mcur_pkg::phase_type                 sel_phase;
   logic [mcur_pkg::WIDTH_W-1:0]        sel_width;

   logic                                s1_valid_ff, s1_trig_ff, s1_report_ff, s1_last_ff;
   logic [mcur_pkg::CHANNEL_W-1:0]      s1_channel_ff;
   logic [mcur_pkg::STATUS_W-1:0]       s1_status_ff;
   logic [mcur_pkg::W17_W-1:0]          s1_w17_ff;

   logic                                rsp_valid_ff, rsp_trig_ff, rsp_report_ff, rsp_last_ff;
   logic [mcur_pkg::CHANNEL_W-1:0]      rsp_channel_ff;
   logic [mcur_pkg::STATUS_W-1:0]       rsp_status_ff;
   logic [mcur_pkg::DIST_W-1:0]         rsp_dist_ff, rsp_dist_in;
   logic [mcur_pkg::PROD_W-1:0]         quot_prod;

   // The whole pipeline moves together whenever the output register can take a value.
   assign advance   = !rsp_valid_ff || !rsp_stall;
   assign req_stall = busy_ff || !advance;

   assign sel_phase = lane_phase[sel_ff];
   assign sel_width = lane_width[sel_ff];

   always_comb begin
      busy_in     = busy_ff;
      sel_in      = sel_ff;
      rep_trig_in = rep_trig_ff;
      iss_valid   = 1'b0;
      iss_trig    = tick.trig;
      iss_report  = 1'b0;
      iss_last    = 1'b1;
      iss_channel = '0;
      iss_status  = mcur_pkg::STATUS_NO_ECHO;
      iss_w17     = '0;
      if (busy_ff) begin
         iss_valid   = 1'b1;
         iss_trig    = rep_trig_ff;
         iss_report  = 1'b1;
         iss_channel = mcur_pkg::CHANNEL_W'(sel_ff);
         iss_last    = (sel_ff == SEL_LAST);
         case (sel_phase)
            mcur_pkg::PHASE_TIMING: iss_status = mcur_pkg::STATUS_UNFINISHED;
            mcur_pkg::PHASE_DONE: begin
               iss_status = mcur_pkg::STATUS_MEASURED;
               iss_w17    = (mcur_pkg::W17_W'(sel_width) << 4)
                          + mcur_pkg::W17_W'(sel_width);
            end
            default: iss_status = mcur_pkg::STATUS_NO_ECHO;
         endcase
         if (advance) begin
            sel_in = sel_ff + SEL_W'(1);
            if (sel_ff == SEL_LAST) begin
               busy_in = 1'b0;
            end
         end
      end else if (tick.accept) begin
         if (tick.is_last) begin
            busy_in     = 1'b1;
            sel_in      = '0;
            rep_trig_in = tick.trig;
         end else begin
            iss_valid = 1'b1;
         end
      end
   end

   assign quot_prod   = mcur_pkg::PROD_W'(s1_w17_ff) * mcur_pkg::PROD_W'(mcur_pkg::RECIP_TEN);
   assign rsp_dist_in = mcur_pkg::DIST_W'(quot_prod >> mcur_pkg::RECIP_TEN_SHIFT);

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff      <= 1'b0;
         sel_ff       <= '0;
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         sel_ff  <= sel_in;
         if (advance) begin
            s1_valid_ff  <= iss_valid;
            rsp_valid_ff <= s1_valid_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      rep_trig_ff <= rep_trig_in;
      if (advance) begin
         s1_trig_ff     <= iss_trig;
         s1_report_ff   <= iss_report;
         s1_last_ff     <= iss_last;
         s1_channel_ff  <= iss_channel;
         s1_status_ff   <= iss_status;
         s1_w17_ff      <= iss_w17;
         rsp_trig_ff    <= s1_trig_ff;
         rsp_report_ff  <= s1_report_ff;
         rsp_last_ff    <= s1_last_ff;
         rsp_channel_ff <= s1_channel_ff;
         rsp_status_ff  <= s1_status_ff;
         rsp_dist_ff    <= rsp_dist_in;
      end
   end

   assign rsp_valid             = rsp_valid_ff;
   assign rsp_trigger_level     = rsp_trig_ff;
   assign rsp_report_valid      = rsp_report_ff;
   assign rsp_channel           = rsp_channel_ff;
   assign rsp_echo_status       = rsp_status_ff;
   assign rsp_distance_tenth_mm = rsp_dist_ff;
   assign rsp_last              = rsp_last_ff;

endmodule

`default_nettype wire

/* rtl/core/mcur_checker.sv */
`default_nettype none

module mcur_checker #(
   parameter int NUM_CHANNELS = mcur_pkg::NUM_CHANNELS_DEFAULT
) (
   input wire logic                                clock,
   input wire logic                                reset,
   input wire logic                                rsp_valid,
   input wire logic                                rsp_stall,
   input wire logic                                rsp_trigger_level,
   input wire logic                                rsp_report_valid,
   input wire logic [mcur_pkg::CHANNEL_W-1:0]      rsp_channel,
   input wire logic [mcur_pkg::STATUS_W-1:0]       rsp_echo_status,
   input wire logic [mcur_pkg::DIST_W-1:0]         rsp_distance_tenth_mm,
   input wire logic                                rsp_last
);

   // A stalled response holds.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_channel)
         && $stable(rsp_distance_tenth_mm) && $stable(rsp_last)
         && $stable(rsp_trigger_level))
      else $error("response changed while stalled");

   // A tick without a report carries the idle fields.
   a_plain_tick: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_report_valid |-> rsp_last && rsp_channel == '0
         && rsp_echo_status == mcur_pkg::STATUS_NO_ECHO && rsp_distance_tenth_mm == '0)
      else $error("plain tick response has report fields set");

   // Only a measured echo has a distance.
   a_dist_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_echo_status != mcur_pkg::STATUS_MEASURED
         |-> rsp_distance_tenth_mm == '0)
      else $error("distance given without a measured echo");

   // A report ends exactly at the highest channel.
   a_report_last: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_report_valid
         |-> rsp_last == (rsp_channel == mcur_pkg::CHANNEL_W'(NUM_CHANNELS - 1)))
      else $error("report last flag does not match the channel");

endmodule

bind multi_channel_ultrasonic_ranger mcur_checker #(
   .NUM_CHANNELS (NUM_CHANNELS)
) u_mcur_checker (
   .clock                 (clock),
   .reset                 (reset),
   .rsp_valid             (rsp_valid),
   .rsp_stall             (rsp_stall),
   .rsp_trigger_level     (rsp_trigger_level),
   .rsp_report_valid      (rsp_report_valid),
   .rsp_channel           (rsp_channel),
   .rsp_echo_status       (rsp_echo_status),
   .rsp_distance_tenth_mm (rsp_distance_tenth_mm),
   .rsp_last              (rsp_last)
);

`default_nettype wire
